// File: hw/rtl/crmu_pkg.sv
// Shared constants, codes and control types for the complex rank-2 update block.
`timescale 1ns / 1ps

package crmu_pkg;

    localparam int ROWS_DEF   = 256;
    localparam int PART_W_DEF = 16;
    localparam int ROW_W      = 8;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_RE = 2'd0,
        CFG_ALPHA_IM = 2'd1,
        CFG_MODE     = 2'd2
    } cfg_idx_t;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Pipeline control handed from the top level to the datapath.
    typedef struct packed {
        logic adv;       // all stages move one step
        logic take_upd;  // an update item enters stage one
        logic cplx;      // complex arithmetic enabled
    } crmu_ctrl_t;

endpackage

// File: hw/rtl/crmu_ifs.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface crmu_item_if import crmu_pkg::*; #(
    parameter int PW = PART_W_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [ROW_W-1:0]     row;
    logic signed [PW-1:0] u_re;
    logic signed [PW-1:0] u_im;
    logic signed [PW-1:0] z_re;
    logic signed [PW-1:0] z_im;
    logic signed [PW-1:0] y_re;
    logic signed [PW-1:0] y_im;
    logic signed [PW-1:0] v_re;
    logic signed [PW-1:0] v_im;
    logic signed [PW-1:0] a_re;
    logic signed [PW-1:0] a_im;

    modport source (
        output valid, opcode, row, u_re, u_im, z_re, z_im,
               y_re, y_im, v_re, v_im, a_re, a_im,
        input  ready
    );
    modport sink (
        input  valid, opcode, row, u_re, u_im, z_re, z_im,
               y_re, y_im, v_re, v_im, a_re, a_im,
        output ready
    );
endinterface

interface crmu_result_if import crmu_pkg::*; #(
    parameter int PW = PART_W_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] new_re;
    logic signed [PW-1:0] new_im;
    logic                 clipped;

    modport source (output valid, new_re, new_im, clipped, input ready);
    modport sink   (input valid, new_re, new_im, clipped, output ready);
endinterface

// File: hw/rtl/complex_rank2_matrix_update.sv
// Top level of the complex rank-2 update: config registers, vector store, pipeline control.
//
//   Channel  | Dir | Handshake        | Beat
//   ---------+-----+------------------+---------------------------------------------
//   item     | in  | valid / ready    | opcode, row, u, z (load) or y, v, a (update)
//   result   | out | valid / ready    | new_re, new_im, clipped (one per update)
//   cfg      | in  | cfg_we only      | cfg_index, cfg_data
//
// One beat per cycle in each direction while no result waits unread; loads and updates may mix freely.
// An accepted update is registered in stage one, then stage two, then the output register.
// The row entry is read from the single-port vector store on the accepting edge, so
// a load is seen by any update behind it with no bypass.
// When a result waits unread, the whole pipeline holds and ready drops.
// Reset clears the pipeline valids and config (alpha 0, complex mode on); no clearing pass.
`timescale 1ns / 1ps

module complex_rank2_matrix_update import crmu_pkg::*; #(
    parameter int ROWS       = ROWS_DEF,
    parameter int PART_WIDTH = PART_W_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PART_WIDTH-1:0] cfg_data,
    crmu_item_if.sink             item,
    crmu_result_if.source         result
);

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Row modulo ROWS by restoring subtraction, one row bit per step.
    function automatic logic [AW-1:0] row_index(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] rem;
        longint           lim;
        rem = r;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            lim = longint'(ROWS) <<< i;
            if (longint'(rem) >= lim)
            begin
                rem = rem - ROW_W'(lim);
            end
        end
        return AW'(rem);
    endfunction

    // Configuration registers.
    logic signed [PART_WIDTH-1:0] alpha_re_reg, alpha_im_reg;
    logic                         complex_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_re_reg     <= '0;
            alpha_im_reg     <= '0;
            complex_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ALPHA_RE: alpha_re_reg     <= cfg_data;
                CFG_ALPHA_IM: alpha_im_reg     <= cfg_data;
                CFG_MODE:     complex_mode_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Pipeline control: every stage advances unless a result sits unread.
    logic                    adv, accept, mem_we, mem_re;
    logic [AW-1:0]           mem_addr;
    logic [4*PART_WIDTH-1:0] mem_wr_data, mem_rd_data;
    crmu_ctrl_t              ctrl;

    assign adv         = !result.valid || result.ready;
    assign item.ready  = adv;
    assign accept      = item.valid && adv;
    assign mem_we      = accept && (item.opcode == OP_LOAD);
    assign mem_re      = accept && (item.opcode == OP_UPDATE);
    assign mem_addr    = row_index(item.row);
    assign mem_wr_data = {item.z_im, item.z_re, item.u_im, item.u_re};

    assign ctrl.adv      = adv;
    assign ctrl.take_upd = mem_re;
    assign ctrl.cplx     = complex_mode_reg;

    crmu_vec_store #(
        .ROWS (ROWS),
        .PW   (PART_WIDTH),
        .AW   (AW)
    ) u_store (
        .clk         (clk),
        .we          (mem_we),
        .re          (mem_re),
        .addr        (mem_addr),
        .wr_data     (mem_wr_data),
        .rd_data_reg (mem_rd_data)
    );

    crmu_datapath #(
        .PW (PART_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .alpha_re      (alpha_re_reg),
        .alpha_im      (alpha_im_reg),
        .y_re          (item.y_re),
        .y_im          (item.y_im),
        .v_re          (item.v_re),
        .v_im          (item.v_im),
        .a_re          (item.a_re),
        .a_im          (item.a_im),
        .rd_data       (mem_rd_data),
        .out_valid_reg (result.valid),
        .new_re_reg    (result.new_re),
        .new_im_reg    (result.new_im),
        .clipped_reg   (result.clipped)
    );

    localparam logic signed [PART_WIDTH-1:0] RAIL_HI = {1'b0, {(PART_WIDTH-1){1'b1}}};
    localparam logic signed [PART_WIDTH-1:0] RAIL_LO = {1'b1, {(PART_WIDTH-1){1'b0}}};

    // The store port is either written or read, never both.
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !mem_re)
        else $error("vector store written and read in one cycle");

    // Input stalls only behind a result that is not taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready))
        else $error("input stalled without output back-pressure");

    // A clipped result has at least one part on a rail.
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.clipped) |->
            (result.new_re == RAIL_HI || result.new_re == RAIL_LO ||
             result.new_im == RAIL_HI || result.new_im == RAIL_LO))
        else $error("clipped flag set with no part saturated");

    // A new result appears only when the pipeline moved.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(adv))
        else $error("result appeared while pipeline held");

endmodule

// File: hw/rtl/crmu_vec_store.sv
// Single-port synchronous memory holding the u and z entries of each row.
`timescale 1ns / 1ps

module crmu_vec_store import crmu_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int PW   = PART_W_DEF,
    parameter int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic            clk,
    input  logic            we,
    input  logic            re,
    input  logic [AW-1:0]   addr,
    input  logic [4*PW-1:0] wr_data,
    output logic [4*PW-1:0] rd_data_reg
);

    logic [4*PW-1:0] mem_array [ROWS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem_array[addr];
        end
    end

endmodule

// File: hw/rtl/crmu_datapath.sv
// Three-stage arithmetic pipeline: alpha products, vector products, sum and saturation.
`timescale 1ns / 1ps

module crmu_datapath import crmu_pkg::*; #(
    parameter int PW = PART_W_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crmu_ctrl_t           ctrl,
    input  logic signed [PW-1:0] alpha_re,
    input  logic signed [PW-1:0] alpha_im,
    input  logic signed [PW-1:0] y_re,
    input  logic signed [PW-1:0] y_im,
    input  logic signed [PW-1:0] v_re,
    input  logic signed [PW-1:0] v_im,
    input  logic signed [PW-1:0] a_re,
    input  logic signed [PW-1:0] a_im,
    input  logic [4*PW-1:0]      rd_data,
    output logic                 out_valid_reg,
    output logic signed [PW-1:0] new_re_reg,
    output logic signed [PW-1:0] new_im_reg,
    output logic                 clipped_reg
);

    localparam int F   = PW - 1;
    localparam int P1W = 2 * PW;
    localparam int P1R = PW + 1;
    localparam int TW  = PW + 2;
    localparam int P2W = 2 * PW + 2;
    localparam int P2R = PW + 3;
    localparam int SW  = PW + 6;

    localparam logic signed [P1W-1:0] HALF1 = {{(P1W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [P2W-1:0] HALF2 = {{(P2W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [PW-1:0]  SAT_HI = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0]  SAT_LO = {1'b1, {(PW-1){1'b0}}};

    // Rounded product, ties toward plus infinity.
    function automatic logic signed [P1R-1:0] mulr1(
        input logic signed [PW-1:0] x,
        input logic signed [PW-1:0] w
    );
        logic signed [P1W-1:0] p;
        p = P1W'(x) * P1W'(w);
        p = p + HALF1;
        return p[P1W-1:F];
    endfunction

    function automatic logic signed [P2R-1:0] mulr2(
        input logic signed [TW-1:0] x,
        input logic signed [PW-1:0] w
    );
        logic signed [P2W-1:0] p;
        p = P2W'(x) * P2W'(w);
        p = p + HALF2;
        return p[P2W-1:F];
    endfunction

    // Stage one: alpha times conj(y) and conj(v), product by product.
    logic signed [PW-1:0]  ai, yi, vi, aei;
    logic                  valid1_reg;
    logic signed [P1R-1:0] p_aryr_reg, p_aiyi_reg, p_aiyr_reg, p_aryi_reg;
    logic signed [P1R-1:0] p_arvr_reg, p_aivi_reg, p_aivr_reg, p_arvi_reg;
    logic signed [PW-1:0]  a_re1_reg, a_im1_reg;

    assign ai  = ctrl.cplx ? alpha_im : '0;
    assign yi  = ctrl.cplx ? y_im : '0;
    assign vi  = ctrl.cplx ? v_im : '0;
    assign aei = ctrl.cplx ? a_im : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            valid1_reg <= ctrl.take_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            p_aryr_reg <= mulr1(alpha_re, y_re);
            p_aiyi_reg <= mulr1(ai, yi);
            p_aiyr_reg <= mulr1(ai, y_re);
            p_aryi_reg <= mulr1(alpha_re, yi);
            p_arvr_reg <= mulr1(alpha_re, v_re);
            p_aivi_reg <= mulr1(ai, vi);
            p_aivr_reg <= mulr1(ai, v_re);
            p_arvi_reg <= mulr1(alpha_re, vi);
            a_re1_reg  <= a_re;
            a_im1_reg  <= aei;
        end
    end

    // Stage two: t and w against the stored u and z entries.
    logic signed [TW-1:0]  t_re, t_im, w_re, w_im;
    logic signed [PW-1:0]  u_re, u_im, z_re, z_im;
    logic                  valid2_reg;
    logic signed [P2R-1:0] q_trur_reg, q_tiui_reg, q_wrzr_reg, q_wizi_reg;
    logic signed [P2R-1:0] q_trui_reg, q_tiur_reg, q_wrzi_reg, q_wizr_reg;
    logic signed [PW-1:0]  a_re2_reg, a_im2_reg;

    assign t_re = TW'(p_aryr_reg) + TW'(p_aiyi_reg);
    assign t_im = TW'(p_aiyr_reg) - TW'(p_aryi_reg);
    assign w_re = TW'(p_arvr_reg) + TW'(p_aivi_reg);
    assign w_im = TW'(p_aivr_reg) - TW'(p_arvi_reg);

    assign u_re = rd_data[PW-1:0];
    assign u_im = ctrl.cplx ? rd_data[2*PW-1:PW] : '0;
    assign z_re = rd_data[3*PW-1:2*PW];
    assign z_im = ctrl.cplx ? rd_data[4*PW-1:3*PW] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            q_trur_reg <= mulr2(t_re, u_re);
            q_tiui_reg <= mulr2(t_im, u_im);
            q_wrzr_reg <= mulr2(w_re, z_re);
            q_wizi_reg <= mulr2(w_im, z_im);
            q_trui_reg <= mulr2(t_re, u_im);
            q_tiur_reg <= mulr2(t_im, u_re);
            q_wrzi_reg <= mulr2(w_re, z_im);
            q_wizr_reg <= mulr2(w_im, z_re);
            a_re2_reg  <= a_re1_reg;
            a_im2_reg  <= a_im1_reg;
        end
    end

    // Stage three: exact sums, then clamp to the part width.
    logic signed [SW-1:0] sum_re, sum_im;
    logic                 re_hi, re_lo, im_hi, im_lo;
    logic signed [PW-1:0] new_re_next, new_im_next;
    logic                 clipped_next;

    assign sum_re = SW'(a_re2_reg) + SW'(q_trur_reg) - SW'(q_tiui_reg)
                  + SW'(q_wrzr_reg) - SW'(q_wizi_reg);
    assign sum_im = SW'(a_im2_reg) + SW'(q_trui_reg) + SW'(q_tiur_reg)
                  + SW'(q_wrzi_reg) + SW'(q_wizr_reg);

    always_comb
    begin
        re_hi = sum_re > SW'(SAT_HI);
        re_lo = sum_re < SW'(SAT_LO);
        im_hi = ctrl.cplx && (sum_im > SW'(SAT_HI));
        im_lo = ctrl.cplx && (sum_im < SW'(SAT_LO));

        if (re_hi)
        begin
            new_re_next = SAT_HI;
        end
        else if (re_lo)
        begin
            new_re_next = SAT_LO;
        end
        else
        begin
            new_re_next = sum_re[PW-1:0];
        end

        if (!ctrl.cplx)
        begin
            new_im_next = '0;
        end
        else if (im_hi)
        begin
            new_im_next = SAT_HI;
        end
        else if (im_lo)
        begin
            new_im_next = SAT_LO;
        end
        else
        begin
            new_im_next = sum_im[PW-1:0];
        end

        clipped_next = re_hi || re_lo || im_hi || im_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            out_valid_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            new_re_reg  <= new_re_next;
            new_im_reg  <= new_im_next;
            clipped_reg <= clipped_next;
        end
    end

endmodule

// File: tb/sv/tb_complex_rank2_matrix_update.sv
// Self-checking testbench for the complex rank-2 update block, with a built-in predictor.
`timescale 1ns / 1ps

module tb_complex_rank2_matrix_update;
    import crmu_pkg::*;

    localparam int PW           = PART_W_DEF;
    localparam int NROWS        = ROWS_DEF;
    localparam int FRAC         = PW - 1;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 75;
    localparam int SETTLE_CYC   = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_PRINT    = 40;

    typedef struct {
        logic              opcode;
        logic [ROW_W-1:0]  row;
        logic [PW-1:0]     u_re, u_im, z_re, z_im;
        logic [PW-1:0]     y_re, y_im, v_re, v_im;
        logic [PW-1:0]     a_re, a_im;
    } item_t;

    typedef struct {
        logic [PW-1:0] re;
        logic [PW-1:0] im;
        logic          clip;
    } elem_t;

    class rank2_scoreboard;
        longint u_mem_re[NROWS], u_mem_im[NROWS];
        longint z_mem_re[NROWS], z_mem_im[NROWS];
        longint alpha_re, alpha_im;
        bit     cplx;
        elem_t  elem_q[$];
        int     errors;

        function new();
            alpha_re = 0;
            alpha_im = 0;
            cplx     = 1'b1;
            errors   = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [PW-1:0] data);
            case (idx)
                CFG_ALPHA_RE: alpha_re = $signed(data);
                CFG_ALPHA_IM: alpha_im = $signed(data);
                CFG_MODE:     cplx = data[0];
                default: ;
            endcase
        endfunction

        // Round a product to FRAC fraction bits, ties toward plus infinity.
        function longint round_mul(longint x, longint y);
            return (x * y + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        endfunction

        function longint clamp(longint v, inout bit hit);
            longint hi, lo;
            hi = (longint'(1) <<< (PW - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                hit = 1'b1;
                return hi;
            end
            if (v < lo)
            begin
                hit = 1'b1;
                return lo;
            end
            return v;
        endfunction

        function void note_item(item_t it);
            longint ar, ai, yr, yi, vr, vi, ur, ui, zr, zi, er, ei;
            longint tr, ti, wr, wi, nr, ni;
            bit     hit;
            elem_t  e;
            int     r;
            r = int'(it.row) % NROWS;
            if (it.opcode == OP_LOAD)
            begin
                // imaginary parts are kept even in real mode
                u_mem_re[r] = $signed(it.u_re);
                u_mem_im[r] = $signed(it.u_im);
                z_mem_re[r] = $signed(it.z_re);
                z_mem_im[r] = $signed(it.z_im);
                return;
            end
            hit = 1'b0;
            ar = alpha_re;
            ai = cplx ? alpha_im : 0;
            yr = $signed(it.y_re);
            yi = cplx ? longint'($signed(it.y_im)) : 0;
            vr = $signed(it.v_re);
            vi = cplx ? longint'($signed(it.v_im)) : 0;
            er = $signed(it.a_re);
            ei = cplx ? longint'($signed(it.a_im)) : 0;
            ur = u_mem_re[r];
            ui = cplx ? u_mem_im[r] : 0;
            zr = z_mem_re[r];
            zi = cplx ? z_mem_im[r] : 0;

            tr = round_mul(ar, yr) + round_mul(ai, yi);
            ti = round_mul(ai, yr) - round_mul(ar, yi);
            wr = round_mul(ar, vr) + round_mul(ai, vi);
            wi = round_mul(ai, vr) - round_mul(ar, vi);

            nr = er + round_mul(tr, ur) - round_mul(ti, ui)
                    + round_mul(wr, zr) - round_mul(wi, zi);
            ni = ei + round_mul(tr, ui) + round_mul(ti, ur)
                    + round_mul(wr, zi) + round_mul(wi, zr);

            nr = clamp(nr, hit);
            ni = cplx ? clamp(ni, hit) : 0;
            e.re   = nr[PW-1:0];
            e.im   = ni[PW-1:0];
            e.clip = hit;
            elem_q.push_back(e);
        endfunction

        function int pending();
            return elem_q.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINT)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [PW-1:0] re, logic [PW-1:0] im, logic clip);
            elem_t e;
            if (elem_q.size() == 0)
            begin
                report($sformatf("result beat with nothing expected (%h %h %b)",
                                 re, im, clip));
                return;
            end
            e = elem_q.pop_front();
            if (re !== e.re)
                report($sformatf("new_re got %h want %h", re, e.re));
            if (im !== e.im)
                report($sformatf("new_im got %h want %h", im, e.im));
            if (clip !== e.clip)
                report($sformatf("clipped got %b want %b", clip, e.clip));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PW-1:0]        cfg_data;

    crmu_item_if   #(.PW(PW)) item_bus ();
    crmu_result_if #(.PW(PW)) res_bus ();

    rank2_scoreboard sb = new();

    bit row_loaded[NROWS];
    int loaded_list[$];
    bit src_burst;
    bit sink_burst;
    int idle_cycles;

    complex_rank2_matrix_update #(
        .ROWS       (NROWS),
        .PART_WIDTH (PW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (res_bus)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [PW-1:0] rand_part();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return PW'($urandom);
        endcase
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.opcode = OP_LOAD;
        it.row    = ROW_W'($urandom);
        it.u_re = rand_part(); it.u_im = rand_part();
        it.z_re = rand_part(); it.z_im = rand_part();
        it.y_re = rand_part(); it.y_im = rand_part();
        it.v_re = rand_part(); it.v_im = rand_part();
        it.a_re = rand_part(); it.a_im = rand_part();
        return it;
    endfunction

    function automatic item_t mk_load(int r, logic [PW-1:0] ur, logic [PW-1:0] ui,
                                      logic [PW-1:0] zr, logic [PW-1:0] zi);
        item_t it;
        it = noise_item();
        it.opcode = OP_LOAD;
        it.row  = ROW_W'(r);
        it.u_re = ur; it.u_im = ui;
        it.z_re = zr; it.z_im = zi;
        return it;
    endfunction

    function automatic item_t mk_update(int r, logic [PW-1:0] yr, logic [PW-1:0] yi,
                                        logic [PW-1:0] vr, logic [PW-1:0] vi,
                                        logic [PW-1:0] er, logic [PW-1:0] ei);
        item_t it;
        it = noise_item();
        it.opcode = OP_UPDATE;
        it.row  = ROW_W'(r);
        it.y_re = yr; it.y_im = yi;
        it.v_re = vr; it.v_im = vi;
        it.a_re = er; it.a_im = ei;
        return it;
    endfunction

    // Mostly updates on loaded rows; loads keep refreshing the stores.
    function automatic item_t random_item();
        item_t it;
        int    r;
        it = noise_item();
        if (loaded_list.size() == 0 || $urandom_range(0, 99) < 30)
        begin
            it.opcode = OP_LOAD;
            if ($urandom_range(0, 9) == 0)
                it.row = $urandom_range(0, 1) ? ROW_W'(NROWS - 1) : '0;
        end
        else
        begin
            r = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            it.opcode = OP_UPDATE;
            it.row    = ROW_W'(r);
        end
        return it;
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(item_t it);
        int gap;
        int r;
        gap = draw_gap(src_burst);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus.opcode <= it.opcode;
        item_bus.row    <= it.row;
        item_bus.u_re   <= it.u_re;
        item_bus.u_im   <= it.u_im;
        item_bus.z_re   <= it.z_re;
        item_bus.z_im   <= it.z_im;
        item_bus.y_re   <= it.y_re;
        item_bus.y_im   <= it.y_im;
        item_bus.v_re   <= it.v_re;
        item_bus.v_im   <= it.v_im;
        item_bus.a_re   <= it.a_re;
        item_bus.a_im   <= it.a_im;
        item_bus.valid  <= 1'b1;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        sb.note_item(it);
        if (it.opcode == OP_LOAD)
        begin
            r = int'(it.row) % NROWS;
            if (!row_loaded[r])
            begin
                row_loaded[r] = 1'b1;
                loaded_list.push_back(r);
            end
        end
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [PW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic set_regs(logic [PW-1:0] are, logic [PW-1:0] aim, logic mode);
        write_reg(CFG_ALPHA_RE, are);
        write_reg(CFG_ALPHA_IM, aim);
        write_reg(CFG_MODE, {(PW-1)'($urandom), mode});
        cfg_we <= 1'b0;
    endtask

    // Hold until every result is back, then idle before returning.
    task automatic drain();
        item_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ALPHA_RE;
        cfg_data  = '0;
        item_bus.valid  = 1'b0;
        item_bus.opcode = OP_LOAD;
        item_bus.row    = '0;
        item_bus.u_re = '0; item_bus.u_im = '0;
        item_bus.z_re = '0; item_bus.z_im = '0;
        item_bus.y_re = '0; item_bus.y_im = '0;
        item_bus.v_re = '0; item_bus.v_im = '0;
        item_bus.a_re = '0; item_bus.a_im = '0;
        src_burst  = 1'b0;
        sink_burst = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: alpha of one half turns ties in the rounding into real cases.
        set_regs(16'h4000, 16'hC000, 1'b1);
        send_item(mk_load(0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
        send_item(mk_load(NROWS - 1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
        send_item(mk_load(1, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF));
        send_item(mk_load(128, 16'h4000, 16'hC000, 16'hFFFF, 16'h0000));
        send_item(mk_update(0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                            16'h7FFF, 16'h8000));
        send_item(mk_update(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h7FFF));
        send_item(mk_update(NROWS - 1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                            16'h8000, 16'h8000));
        send_item(mk_update(NROWS - 1, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000,
                            16'h7FFF, 16'h7FFF));
        send_item(mk_update(1, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001,
                            16'h0000, 16'h0000));
        send_item(mk_update(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            16'd12345, -16'sd12345));
        send_item(mk_update(128, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'h0001));
        // reload a row and hit it on the very next beat
        send_item(mk_load(1, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000));
        send_item(mk_update(1, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF,
                            16'h0000, 16'h0000));
        send_item(mk_load(77, rand_part(), rand_part(), rand_part(), rand_part()));
        send_item(mk_update(77, rand_part(), rand_part(), rand_part(), rand_part(),
                            rand_part(), rand_part()));
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       set_regs(16'h7FFF, 16'h8000, 1'b1);
                1:       set_regs(16'h8000, 16'h7FFF, 1'b0);
                2:       set_regs(16'h8000, 16'h8000, 1'b1);
                3:       set_regs(16'h0000, 16'h0000, 1'b1);
                4:       set_regs(16'h7FFF, 16'h7FFF, 1'b0);
                default: set_regs(PW'($urandom), PW'($urandom), 1'($urandom));
            endcase
            src_burst  = (p % 3 == 1);
            sink_burst = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
            drain();
        end

        if (sb.errors == 0)
            $display("complex_rank2_matrix_update regression: pass");
        else
            $display("complex_rank2_matrix_update regression: fail");
        $finish;
    end

    // Result side: random stall before each beat, then wait for it.
    initial
    begin
        int gap;
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(sink_burst);
            if (gap > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (!res_bus.valid)
                @(posedge clk);
            sb.check_result(res_bus.new_re, res_bus.new_im, res_bus.clipped);
            @(negedge clk);
        end
    end

    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("complex_rank2_matrix_update regression: fail");
            $finish;
        end
    end

endmodule

// File: files.f
hw/rtl/crmu_pkg.sv
hw/rtl/crmu_ifs.sv
hw/rtl/crmu_vec_store.sv
hw/rtl/crmu_datapath.sv
hw/rtl/complex_rank2_matrix_update.sv
tb/sv/tb_complex_rank2_matrix_update.sv
